>>> rtl/core/lfpd_pkg.sv
// ----------------------------------------------------------------------------
// lfpd_pkg
// Types, widths and codes shared by the line follower PID drive block.
// ----------------------------------------------------------------------------
`default_nettype none

package lfpd_pkg;

  // Field and datapath widths
  localparam int unsigned SUM_BITS = 21;           // integral accumulator width
  localparam int unsigned GAIN_W   = 16;           // Q8.8 gains
  localparam int unsigned SPEED_W  = 8;            // base speeds, magnitudes
  localparam int unsigned TIME_W   = 32;           // millisecond timestamp
  localparam int unsigned ERR_W    = 6;            // line error, half units
  localparam int unsigned DERR_W   = ERR_W + 1;    // error difference
  localparam int unsigned FRAC_W   = 9;            // products are in 1/512 units
  localparam int unsigned PP_W     = GAIN_W + 1 + ERR_W;
  localparam int unsigned PI_W     = GAIN_W + 1 + SUM_BITS;
  localparam int unsigned PD_W     = GAIN_W + 1 + DERR_W;
  localparam int unsigned T_W      = PI_W + 2;     // sum of the three products
  localparam int unsigned DRV_W    = T_W + 1;      // base term plus correction
  localparam int unsigned Q_W      = DRV_W - FRAC_W;
  localparam int unsigned CFG_W    = 16;           // widest register
  localparam int unsigned CFG_IDX_W = 3;

  // Register reset values
  localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd8960;
  localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd13;
  localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd1280;
  localparam logic [SPEED_W-1:0] BASE_RST      = 8'd255;
  localparam logic [SPEED_W-1:0] STOP_HOLD_RST = 8'd40;
  localparam logic [SPEED_W-1:0] MAG_MAX       = 8'd255;

  // Line error values in half units
  localparam logic signed [ERR_W-1:0] ERR_ZERO      = 6'sd0;
  localparam logic signed [ERR_W-1:0] ERR_NEAR_POS  = 6'sd1;
  localparam logic signed [ERR_W-1:0] ERR_NEAR_NEG  = -6'sd1;
  localparam logic signed [ERR_W-1:0] ERR_MID_POS   = 6'sd2;
  localparam logic signed [ERR_W-1:0] ERR_MID_NEG   = -6'sd2;
  localparam logic signed [ERR_W-1:0] ERR_LOST_POS  = 6'sd24;
  localparam logic signed [ERR_W-1:0] ERR_LOST_NEG  = -6'sd24;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P     = 3'd0,
    REG_GAIN_I     = 3'd1,
    REG_GAIN_D     = 3'd2,
    REG_BASE_LEFT  = 3'd3,
    REG_BASE_RIGHT = 3'd4,
    REG_STOP_HOLD  = 3'd5
  } cfg_reg_e;

  // Last turn codes
  typedef enum logic [1:0] {
    TURN_STRAIGHT = 2'd0,
    TURN_LEFT     = 2'd1,
    TURN_RIGHT    = 2'd2
  } turn_e;

  // Motor direction codes
  localparam logic [1:0] DIR_OFF = 2'd0;
  localparam logic [1:0] DIR_FWD = 2'd1;
  localparam logic [1:0] DIR_REV = 2'd2;

  // Input word
  typedef struct packed {
    logic              start_request;
    logic              left_sensor;
    logic              middle_sensor;
    logic              right_sensor;
    logic [TIME_W-1:0] now_ms;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [SPEED_W-1:0] left_magnitude;
    logic [1:0]         left_direction;
    logic [SPEED_W-1:0] right_magnitude;
    logic [1:0]         right_direction;
    logic               running;
  } out_word_t;

  // Configuration registers
  typedef struct packed {
    logic [GAIN_W-1:0]  gain_p;
    logic [GAIN_W-1:0]  gain_i;
    logic [GAIN_W-1:0]  gain_d;
    logic [SPEED_W-1:0] base_left;
    logic [SPEED_W-1:0] base_right;
    logic [SPEED_W-1:0] stop_hold;
  } cfg_t;

  // Output overrides carried down the pipe
  typedef struct packed {
    logic force_zero;   // idle tick or stop: both drives 0
    logic force_full;   // all sensors on line, going straight: full forward
    logic running;
  } ctl_t;

  // Stage 1 word: controller terms after the state update
  typedef struct packed {
    logic signed [ERR_W-1:0]    err;
    logic signed [DERR_W-1:0]   derr;
    logic signed [SUM_BITS-1:0] sum;
    ctl_t                       ctl;
  } track_t;

  // Stage 2 word: gain products
  typedef struct packed {
    logic signed [PP_W-1:0] prod_p;
    logic signed [PI_W-1:0] prod_i;
    logic signed [PD_W-1:0] prod_d;
    ctl_t                   ctl;
  } prod_t;

endpackage

`default_nettype wire

>>> rtl/core/lfpd_track.sv
// ----------------------------------------------------------------------------
// lfpd_track
// Sensor decode, run/stop control and integral update; holds the loop state
// and registers one word of controller terms per accepted tick.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_track (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire lfpd_pkg::in_word_t in_word_i,
  input  wire lfpd_pkg::cfg_t    cfg_i,
  output logic                   trk_valid_o,
  input  wire logic              trk_ready_i,
  output lfpd_pkg::track_t       trk_o
);

  localparam int unsigned SB = lfpd_pkg::SUM_BITS;

  // Pattern codes, left/middle/right with middle inverted
  localparam logic [2:0] PAT_R     = 3'b001;
  localparam logic [2:0] PAT_MR    = 3'b011;
  localparam logic [2:0] PAT_L     = 3'b100;
  localparam logic [2:0] PAT_LR    = 3'b101;
  localparam logic [2:0] PAT_LM    = 3'b110;
  localparam logic [2:0] PAT_ALL   = 3'b111;

  localparam logic signed [SB-1:0] SUM_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] SUM_MIN = {1'b1, {(SB-1){1'b0}}};

  // Loop state
  logic                               run_q, run_d;
  logic signed [lfpd_pkg::ERR_W-1:0]  err_q, err_d;
  logic signed [SB-1:0]               sum_q, sum_d;
  lfpd_pkg::turn_e                    turn_q, turn_d;
  logic                               pend_q, pend_d;
  logic [lfpd_pkg::TIME_W-1:0]        since_q, since_d;

  logic                               valid_q;
  lfpd_pkg::track_t                   word_q, word_d;

  logic                               accept;
  logic                               start;
  logic                               idle;
  logic [2:0]                         pat;
  logic signed [lfpd_pkg::ERR_W-1:0]  err0, err_n;
  logic signed [SB-1:0]               sum0;
  lfpd_pkg::turn_e                    turn0, turn_n;
  logic                               pend0;
  logic signed [SB:0]                 sum_ext;
  logic signed [SB-1:0]               sum_n;
  logic [lfpd_pkg::TIME_W-1:0]        elapsed;
  logic                               stop_fire;

  assign in_ready_o  = !valid_q || trk_ready_i;
  assign accept      = in_valid_i && in_ready_o;
  assign trk_valid_o = valid_q;
  assign trk_o       = word_q;

  // Decode the tick and work out the next loop state
  always_comb begin
    start = !run_q && in_word_i.start_request;
    idle  = !run_q && !in_word_i.start_request;
    pat   = {in_word_i.left_sensor, !in_word_i.middle_sensor, in_word_i.right_sensor};

    // a starting run clears the controller memory
    err0  = start ? lfpd_pkg::ERR_ZERO : err_q;
    sum0  = start ? '0 : sum_q;
    turn0 = start ? lfpd_pkg::TURN_STRAIGHT : turn_q;
    pend0 = start ? 1'b0 : pend_q;

    err_n  = err0;
    turn_n = turn0;
    case (pat)
      PAT_R: begin
        err_n  = lfpd_pkg::ERR_NEAR_NEG;
        turn_n = lfpd_pkg::TURN_LEFT;
      end
      PAT_MR: begin
        err_n  = lfpd_pkg::ERR_MID_NEG;
        turn_n = lfpd_pkg::TURN_LEFT;
      end
      PAT_L: begin
        err_n  = lfpd_pkg::ERR_NEAR_POS;
        turn_n = lfpd_pkg::TURN_RIGHT;
      end
      PAT_LR: begin
        err_n  = lfpd_pkg::ERR_ZERO;
        turn_n = lfpd_pkg::TURN_STRAIGHT;
      end
      PAT_LM: begin
        err_n  = lfpd_pkg::ERR_MID_POS;
        turn_n = lfpd_pkg::TURN_RIGHT;
      end
      PAT_ALL: begin
        // line lost under all sensors: steer hard the last way we turned
        if (turn0 == lfpd_pkg::TURN_LEFT) begin
          err_n = lfpd_pkg::ERR_LOST_NEG;
        end else if (turn0 == lfpd_pkg::TURN_RIGHT) begin
          err_n = lfpd_pkg::ERR_LOST_POS;
        end else begin
          err_n = lfpd_pkg::ERR_ZERO;
        end
      end
      default: begin
        // no new reading: hold error and turn
      end
    endcase

    // saturating integral
    sum_ext = {sum0[SB-1], sum0} + {{(SB+1-lfpd_pkg::ERR_W){err_n[lfpd_pkg::ERR_W-1]}}, err_n};
    if (sum_ext[SB] != sum_ext[SB-1]) begin
      sum_n = sum_ext[SB] ? SUM_MIN : SUM_MAX;
    end else begin
      sum_n = sum_ext[SB-1:0];
    end

    // stop detection on both outer sensors low
    elapsed   = in_word_i.now_ms - since_q;
    stop_fire = 1'b0;
    pend_d    = pend0;
    since_d   = since_q;
    if (!in_word_i.left_sensor && !in_word_i.right_sensor) begin
      if (pend0 && (elapsed > {{(lfpd_pkg::TIME_W-lfpd_pkg::SPEED_W){1'b0}}, cfg_i.stop_hold})) begin
        stop_fire = 1'b1;
      end else if (!pend0) begin
        pend_d  = 1'b1;
        since_d = in_word_i.now_ms;
      end
    end else begin
      pend_d = 1'b0;
    end

    run_d  = !stop_fire;
    err_d  = err_n;
    sum_d  = sum_n;
    turn_d = turn_n;

    word_d.err  = err_n;
    word_d.derr = {err_n[lfpd_pkg::ERR_W-1], err_n} - {err0[lfpd_pkg::ERR_W-1], err0};
    word_d.sum  = sum_n;
    word_d.ctl.force_zero = idle || stop_fire;
    word_d.ctl.force_full = !idle && (pat == PAT_ALL) && (turn_n == lfpd_pkg::TURN_STRAIGHT);
    word_d.ctl.running    = !idle && !stop_fire;
  end

  // Commit loop state on run ticks only
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q   <= 1'b0;
      err_q   <= lfpd_pkg::ERR_ZERO;
      sum_q   <= '0;
      turn_q  <= lfpd_pkg::TURN_STRAIGHT;
      pend_q  <= 1'b0;
      since_q <= '0;
    end else if (accept && !idle) begin
      run_q   <= run_d;
      err_q   <= err_d;
      sum_q   <= sum_d;
      turn_q  <= turn_d;
      pend_q  <= pend_d;
      since_q <= since_d;
    end
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Stage word
  always_ff @(posedge clk_i) begin
    if (accept) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfpd_mult.sv
// ----------------------------------------------------------------------------
// lfpd_mult
// Gain products: proportional, integral and derivative terms, registered.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_mult (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             trk_valid_i,
  output logic                  trk_ready_o,
  input  wire lfpd_pkg::track_t trk_i,
  input  wire lfpd_pkg::cfg_t   cfg_i,
  output logic                  prd_valid_o,
  input  wire logic             prd_ready_i,
  output lfpd_pkg::prod_t       prd_o
);

  logic                                    valid_q;
  lfpd_pkg::prod_t                         word_q, word_d;
  logic                                    advance;
  logic signed [lfpd_pkg::GAIN_W:0]        kp, ki, kd;

  assign trk_ready_o = !valid_q || prd_ready_i;
  assign advance     = trk_valid_i && trk_ready_o;
  assign prd_valid_o = valid_q;
  assign prd_o       = word_q;

  // Multiply unsigned gains by signed terms
  always_comb begin
    kp = {1'b0, cfg_i.gain_p};
    ki = {1'b0, cfg_i.gain_i};
    kd = {1'b0, cfg_i.gain_d};
    word_d.prod_p = kp * trk_i.err;
    word_d.prod_i = ki * trk_i.sum;
    word_d.prod_d = kd * trk_i.derr;
    word_d.ctl    = trk_i.ctl;
  end

  // Stage valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (trk_ready_o) begin
      valid_q <= trk_valid_i;
    end
  end

  // Stage word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/lfpd_drive.sv
// ----------------------------------------------------------------------------
// lfpd_drive
// Combine the PID terms with the base speeds, scale to whole drive units,
// split into direction and clamped magnitude; holds the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module lfpd_drive (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               prd_valid_i,
  output logic                    prd_ready_o,
  input  wire lfpd_pkg::prod_t    prd_i,
  input  wire lfpd_pkg::cfg_t     cfg_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output lfpd_pkg::out_word_t     out_word_o
);

  localparam int unsigned TW = lfpd_pkg::T_W;
  localparam int unsigned DW = lfpd_pkg::DRV_W;
  localparam int unsigned QW = lfpd_pkg::Q_W;
  localparam int unsigned FW = lfpd_pkg::FRAC_W;
  localparam int unsigned SW = lfpd_pkg::SPEED_W;

  logic                    valid_q;
  lfpd_pkg::out_word_t     word_q, word_d;
  logic                    advance;
  logic signed [TW-1:0]    corr;
  logic signed [DW-1:0]    base_l, base_r;
  logic signed [DW-1:0]    drv_l, drv_r;
  logic [SW-1:0]           mag_l, mag_r;
  logic [1:0]              dir_l, dir_r;

  assign prd_ready_o = !valid_q || out_ready_i;
  assign advance     = prd_valid_i && prd_ready_o;
  assign out_valid_o = valid_q;
  assign out_word_o  = word_q;

  // Scale a drive by 1/512 rounding toward zero, then split sign and size
  function automatic logic [SW+1:0] split_drive(input logic signed [DW-1:0] d);
    logic signed [DW-1:0] adj;
    logic signed [QW-1:0] q;
    logic [QW-1:0]        a;
    logic [SW-1:0]        mag;
    logic [1:0]           dir;
    adj = d + {{(DW-FW){1'b0}}, {FW{d[DW-1]}}};
    q   = adj[DW-1:FW];
    a   = q[QW-1] ? QW'(-q) : QW'(q);
    mag = (a[QW-1:SW] != '0) ? lfpd_pkg::MAG_MAX : a[SW-1:0];
    if (q[QW-1]) begin
      dir = lfpd_pkg::DIR_REV;
    end else if (q != '0) begin
      dir = lfpd_pkg::DIR_FWD;
    end else begin
      dir = lfpd_pkg::DIR_OFF;
    end
    return {mag, dir};
  endfunction

  // Form both drives and apply the overrides
  always_comb begin
    corr = {{(TW-lfpd_pkg::PP_W){prd_i.prod_p[lfpd_pkg::PP_W-1]}}, prd_i.prod_p}
         + {{(TW-lfpd_pkg::PI_W){prd_i.prod_i[lfpd_pkg::PI_W-1]}}, prd_i.prod_i}
         + {{(TW-lfpd_pkg::PD_W){prd_i.prod_d[lfpd_pkg::PD_W-1]}}, prd_i.prod_d};
    base_l = {{(DW-SW-FW){1'b0}}, cfg_i.base_left, {FW{1'b0}}};
    base_r = {{(DW-SW-FW){1'b0}}, cfg_i.base_right, {FW{1'b0}}};
    drv_l  = base_l + {corr[TW-1], corr};
    drv_r  = base_r - {corr[TW-1], corr};
    {mag_l, dir_l} = split_drive(drv_l);
    {mag_r, dir_r} = split_drive(drv_r);

    word_d.left_magnitude  = mag_l;
    word_d.left_direction  = dir_l;
    word_d.right_magnitude = mag_r;
    word_d.right_direction = dir_r;
    word_d.running         = prd_i.ctl.running;
    if (prd_i.ctl.force_zero) begin
      word_d.left_magnitude  = '0;
      word_d.left_direction  = lfpd_pkg::DIR_OFF;
      word_d.right_magnitude = '0;
      word_d.right_direction = lfpd_pkg::DIR_OFF;
    end else if (prd_i.ctl.force_full) begin
      word_d.left_magnitude  = lfpd_pkg::MAG_MAX;
      word_d.left_direction  = lfpd_pkg::DIR_FWD;
      word_d.right_magnitude = lfpd_pkg::MAG_MAX;
      word_d.right_direction = lfpd_pkg::DIR_FWD;
    end
  end

  // Result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (prd_ready_o) begin
      valid_q <= prd_valid_i;
    end
  end

  // Result word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      word_q <= word_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/line_follower_pid_drive_top.sv
// ----------------------------------------------------------------------------
// line_follower_pid_drive_top
// Three-sensor line follower PID drive controller, one result word per tick.
// ----------------------------------------------------------------------------
//  channel   direction  handshake               payload
//  input     in         in_valid_i/in_ready_o   in_word_i  (lfpd_pkg::in_word_t)
//  result    out        out_valid_o/out_ready_i out_word_o (lfpd_pkg::out_word_t)
//  config    in         cfg_we_i                cfg_idx_i, cfg_wdata_i
//
//  One word per cycle while results are taken; a word passes through the
//  state update stage, the gain multiply stage and the result register.
//  The loop state (error, integral, last turn, stop timer) updates in the
//  first stage, so consecutive ticks follow in back-to-back cycles.
//  Each stage stalls only when the stage after it is full and held.
//  Reset clears all loop state and loads the register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module line_follower_pid_drive_top (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire lfpd_pkg::in_word_t               in_word_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output lfpd_pkg::out_word_t                   out_word_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lfpd_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lfpd_pkg::CFG_W-1:0]       cfg_wdata_i
);

  lfpd_pkg::cfg_t   cfg_q;
  logic             trk_valid, trk_ready;
  lfpd_pkg::track_t trk;
  logic             prd_valid, prd_ready;
  lfpd_pkg::prod_t  prd;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain_p     <= lfpd_pkg::GAIN_P_RST;
      cfg_q.gain_i     <= lfpd_pkg::GAIN_I_RST;
      cfg_q.gain_d     <= lfpd_pkg::GAIN_D_RST;
      cfg_q.base_left  <= lfpd_pkg::BASE_RST;
      cfg_q.base_right <= lfpd_pkg::BASE_RST;
      cfg_q.stop_hold  <= lfpd_pkg::STOP_HOLD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfpd_pkg::REG_GAIN_P:     cfg_q.gain_p     <= cfg_wdata_i;
        lfpd_pkg::REG_GAIN_I:     cfg_q.gain_i     <= cfg_wdata_i;
        lfpd_pkg::REG_GAIN_D:     cfg_q.gain_d     <= cfg_wdata_i;
        lfpd_pkg::REG_BASE_LEFT:  cfg_q.base_left  <= cfg_wdata_i[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::REG_BASE_RIGHT: cfg_q.base_right <= cfg_wdata_i[lfpd_pkg::SPEED_W-1:0];
        lfpd_pkg::REG_STOP_HOLD:  cfg_q.stop_hold  <= cfg_wdata_i[lfpd_pkg::SPEED_W-1:0];
        default: begin
          // unused index: drop the write
        end
      endcase
    end
  end

  lfpd_track u_track (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_word_i   (in_word_i),
    .cfg_i       (cfg_q),
    .trk_valid_o (trk_valid),
    .trk_ready_i (trk_ready),
    .trk_o       (trk)
  );

  lfpd_mult u_mult (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .trk_valid_i (trk_valid),
    .trk_ready_o (trk_ready),
    .trk_i       (trk),
    .cfg_i       (cfg_q),
    .prd_valid_o (prd_valid),
    .prd_ready_i (prd_ready),
    .prd_o       (prd)
  );

  lfpd_drive u_drive (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .prd_valid_i (prd_valid),
    .prd_ready_o (prd_ready),
    .prd_i       (prd),
    .cfg_i       (cfg_q),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
